// ----- hdl/spq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Operation codes on the command input
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ENQ = 2'd0,
    ST_DEQ = 2'd1,
    ST_OVF = 2'd2,
    ST_UNF = 2'd3
  } status_e;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_e;

  // Operation issued to the datapath
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ENQ  = 3'd1,
    OP_DEQ  = 3'd2,
    OP_OVF  = 3'd3,
    OP_UNF  = 3'd4
  } op_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic cmd_deq;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/spq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output ctrl_t         ctrl_o,
  output logic          busy_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    ctrl_o.load  = 1'b0;
    ctrl_o.op    = OP_NONE;
    busy_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_RUN;
        end
      end
      S_RUN: begin
        busy_o  = 1'b1;
        state_d = S_IDLE;
        // pick the operation from the latched command and fill level
        priority if (stat_i.cmd_deq && stat_i.empty) begin
          ctrl_o.op = OP_UNF;
        end else if (stat_i.cmd_deq) begin
          ctrl_o.op = OP_DEQ;
        end else if (stat_i.full) begin
          ctrl_o.op = OP_OVF;
        end else begin
          ctrl_o.op = OP_ENQ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/spq_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spq_dp
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ctrl_t              ctrl_i,
  input  wire logic               cmd_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic        [7:0]  item_priority_i,
  output dp_stat_t                stat_o,
  output logic                    done_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] out_value_o,
  output logic             [7:0]  out_priority_o,
  output logic             [3:0]  occupancy_o
);

  localparam int CW = $clog2(DEPTH + 1);

  // Latched operands
  logic        cmd_q;
  logic [31:0] in_val_q;
  logic [7:0]  in_pri_q;

  // Sorted cell array, head at index 0
  logic [31:0] val_q [DEPTH];
  logic [7:0]  pri_q [DEPTH];
  logic [31:0] val_d [DEPTH];
  logic [7:0]  pri_d [DEPTH];
  logic [DEPTH-1:0] gt;

  logic [CW-1:0] count_q, count_d;

  // Result registers
  logic        done_q;
  logic [1:0]  status_q;
  logic [31:0] res_val_q;
  logic [7:0]  res_pri_q;
  logic [3:0]  occ_q;

  // Operand capture
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q    <= cmd_i;
      in_val_q <= item_value_i;
      in_pri_q <= item_priority_i;
    end
  end

  assign stat_o.cmd_deq = (cmd_q == CMD_DEQ);
  assign stat_o.full    = (count_q == CW'(DEPTH));
  assign stat_o.empty   = (count_q == '0);

  // Per-cell compare and shift
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic        lo_gt;
    logic [31:0] lo_val;
    logic [7:0]  lo_pri;
    logic [31:0] hi_val;
    logic [7:0]  hi_pri;

    // occupied cell holding a strictly larger priority moves up on insert
    assign gt[k] = (CW'(k) < count_q) && (in_pri_q < pri_q[k]);

    if (k == 0) begin : g_lo_none
      assign lo_gt  = 1'b0;
      assign lo_val = val_q[k];
      assign lo_pri = pri_q[k];
    end else begin : g_lo
      assign lo_gt  = gt[k-1];
      assign lo_val = val_q[k-1];
      assign lo_pri = pri_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_hi_none
      assign hi_val = val_q[k];
      assign hi_pri = pri_q[k];
    end else begin : g_hi
      assign hi_val = val_q[k+1];
      assign hi_pri = pri_q[k+1];
    end

    always_comb begin
      val_d[k] = val_q[k];
      pri_d[k] = pri_q[k];
      if (ctrl_i.op == OP_ENQ) begin
        if (lo_gt) begin
          val_d[k] = lo_val;
          pri_d[k] = lo_pri;
        end else if (gt[k] || (count_q == CW'(k))) begin
          val_d[k] = in_val_q;
          pri_d[k] = in_pri_q;
        end
      end else if (ctrl_i.op == OP_DEQ) begin
        val_d[k] = hi_val;
        pri_d[k] = hi_pri;
      end
    end

    always_ff @(posedge clk_i) begin
      val_q[k] <= val_d[k];
      pri_q[k] <= pri_d[k];
    end
  end

  // Fill count
  always_comb begin
    count_d = count_q;
    if (ctrl_i.op == OP_ENQ) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.op == OP_DEQ) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= (ctrl_i.op != OP_NONE);
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op != OP_NONE) begin
      occ_q <= 4'(count_d);
      unique case (ctrl_i.op)
        OP_ENQ: begin
          status_q  <= ST_ENQ;
          res_val_q <= '0;
          res_pri_q <= '0;
        end
        OP_DEQ: begin
          status_q  <= ST_DEQ;
          res_val_q <= val_q[0];
          res_pri_q <= pri_q[0];
        end
        OP_OVF: begin
          status_q  <= ST_OVF;
          res_val_q <= '0;
          res_pri_q <= '0;
        end
        OP_UNF: begin
          status_q  <= ST_UNF;
          res_val_q <= '0;
          res_pri_q <= '0;
        end
        default: begin
          status_q  <= ST_ENQ;
          res_val_q <= '0;
          res_pri_q <= '0;
        end
      endcase
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_value_o    = res_val_q;
  assign out_priority_o = res_pri_q;
  assign occupancy_o    = occ_q;

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue.sv -----
// Channel   Signals                                          Handshake
// command   cmd_i, item_value_i, item_priority_i             start_i high, busy_o low
// result    status_o, out_value_o, out_priority_o,           done_o, one cycle
//           occupancy_o
//
// The accept edge latches the operands and moves the controller to S_RUN; in
// S_RUN every cell of the sorted register array is updated at once and the result
// registers are loaded, then shown on done_o. busy_o is high for one cycle after
// each transfer, and no command is taken until the controller is back in S_IDLE.
// Reset clears the fill count and the controller; cell contents are not reset.
// Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic               cmd_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic        [7:0]  item_priority_i,
  output logic                    done_o,
  output logic             [1:0]  status_o,
  output logic signed      [31:0] out_value_o,
  output logic             [7:0]  out_priority_o,
  output logic             [3:0]  occupancy_o
);

  ctrl_t    ctrl;
  dp_stat_t stat;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  // Cell array and result registers
  spq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cmd_i           (cmd_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .stat_o          (stat),
    .done_o          (done_o),
    .status_o        (status_o),
    .out_value_o     (out_value_o),
    .out_priority_o  (out_priority_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

`default_nettype wire

// ----- dv/spq_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the sorted priority queue, keeps its own sorted
// store, and compares every result transfer with the oldest prediction.
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic               cmd_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic        [7:0]  item_priority_i,
  input  wire logic               done_i,
  input  wire logic        [1:0]  status_i,
  input  wire logic signed [31:0] out_value_i,
  input  wire logic        [7:0]  out_priority_i,
  input  wire logic        [3:0]  occupancy_i,
  output int                      err_count_o,
  output int                      pending_o
);

  typedef struct {
    status_e            status;
    logic signed [31:0] value;
    logic        [7:0]  prio;
    logic        [3:0]  occ;
  } queue_reply_t;

  // Shadow copy of the sorted store, head at index 0
  logic signed [31:0] shadow_value [DEPTH];
  logic        [7:0]  shadow_prio  [DEPTH];
  int                 shadow_fill;

  queue_reply_t replies_due[$];
  queue_reply_t want;
  int           fail_count;

  initial begin
    err_count_o = 0;
    pending_o   = 0;
    fail_count  = 0;
    shadow_fill = 0;
  end

  // Applies one command to the shadow store and returns the reply it gives
  function automatic queue_reply_t apply_queue_op(input logic c,
                                                  input logic signed [31:0] v,
                                                  input logic [7:0] p);
    queue_reply_t r;
    int pos;
    r.status = ST_ENQ;
    r.value  = '0;
    r.prio   = '0;
    if (c == CMD_ENQ) begin
      if (shadow_fill >= DEPTH) begin
        r.status = ST_OVF;
      end else begin
        // entries with a strictly larger key move one slot toward the tail
        pos = shadow_fill;
        while (pos > 0 && p < shadow_prio[pos-1]) begin
          shadow_value[pos] = shadow_value[pos-1];
          shadow_prio[pos]  = shadow_prio[pos-1];
          pos--;
        end
        shadow_value[pos] = v;
        shadow_prio[pos]  = p;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        r.status = ST_UNF;
      end else begin
        r.status = ST_DEQ;
        r.value  = shadow_value[0];
        r.prio   = shadow_prio[0];
        for (int k = 0; k + 1 < shadow_fill; k++) begin
          shadow_value[k] = shadow_value[k+1];
          shadow_prio[k]  = shadow_prio[k+1];
        end
        shadow_fill--;
      end
    end
    r.occ = 4'(shadow_fill);
    return r;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    err_count_o = fail_count;
    if (fail_count <= 10) $display("%t ERROR %s", $realtime, msg);
  endtask

  // Result side is checked before the command side: a result never belongs
  // to a command accepted at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      replies_due.delete();
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (replies_due.size() == 0) begin
          log_failure($sformatf("result with none expected: st=%0d val=%0d pri=%0d occ=%0d",
                                status_i, out_value_i, out_priority_i, occupancy_i));
        end else begin
          want = replies_due.pop_front();
          if (status_i !== want.status || out_value_i !== want.value ||
              out_priority_i !== want.prio || occupancy_i !== want.occ) begin
            log_failure($sformatf({"result mismatch: exp st=%0d val=%0d pri=%0d occ=%0d",
                                   " got st=%0d val=%0d pri=%0d occ=%0d"},
                                  want.status, want.value, want.prio, want.occ,
                                  status_i, out_value_i, out_priority_i, occupancy_i));
          end
        end
      end
      if (start_i && !busy_i) begin
        replies_due.push_back(apply_queue_op(cmd_i, item_value_i, item_priority_i));
      end
      pending_o = replies_due.size();
    end
  end

endmodule

// ----- dv/tb_sorted_priority_queue.sv -----
`timescale 1ns / 1ps

// Drives command transfers into the queue under several sender idle patterns
// and gives the verdict from the checker's counts.
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               cmd_i;
  logic signed [31:0] item_value_i;
  logic        [7:0]  item_priority_i;
  logic               done_o;
  logic        [1:0]  status_o;
  logic signed [31:0] out_value_o;
  logic        [7:0]  out_priority_o;
  logic        [3:0]  occupancy_o;

  int err_count;
  int pending;
  int idle_pct;

  sorted_priority_queue #(.DEPTH(DEPTH)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_value_o    (out_value_o),
    .out_priority_o (out_priority_o),
    .occupancy_o    (occupancy_o)
  );

  spq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .cmd_i          (cmd_i),
    .item_value_i   (item_value_i),
    .item_priority_i(item_priority_i),
    .done_i         (done_o),
    .status_i       (status_o),
    .out_value_i    (out_value_o),
    .out_priority_i (out_priority_o),
    .occupancy_i    (occupancy_o),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // One command transfer; called and returns at a falling edge
  task automatic send_cmd(input logic c, input logic signed [31:0] v, input logic [7:0] p);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i         <= 1'b1;
    cmd_i           <= c;
    item_value_i    <= v;
    item_priority_i <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Holds the sender off until every outstanding result has arrived
  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int                 phase_idle [4];
    int                 enq_bias;
    logic               c;
    logic signed [31:0] v;
    logic        [7:0]  p;
    int                 sel;

    phase_idle      = '{0, 70, 0, 38};
    idle_pct        = 0;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = CMD_ENQ;
    item_value_i    = '0;
    item_priority_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: underflow, extremes, ties in arrival order, fill, overflow, drain
    send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    send_cmd(CMD_ENQ, 32'sh7fffffff, 8'd255);
    send_cmd(CMD_ENQ, 32'sh80000000, 8'd0);
    send_cmd(CMD_ENQ, 32'sd0, 8'd255);
    send_cmd(CMD_ENQ, -32'sd1, 8'd128);
    send_cmd(CMD_ENQ, 32'sd1, 8'd0);
    send_cmd(CMD_ENQ, 32'sha5a5a5a5, 8'd7);
    send_cmd(CMD_ENQ, 32'sh5a5a5a5a, 8'd200);
    send_cmd(CMD_ENQ, 32'sd12345, 8'd7);
    send_cmd(CMD_ENQ, -32'sd77, 8'd1);
    repeat (DEPTH) send_cmd(CMD_DEQ, 32'sh7fffffff, 8'd255);
    send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    send_cmd(CMD_ENQ, 32'sh55555555, 8'h55);
    send_cmd(CMD_ENQ, 32'shaaaaaaaa, 8'haa);
    send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    send_cmd(CMD_DEQ, 32'sd0, 8'd0);
    drain_results();

    // Random: four phases of sender idle settings, enqueue bias changed every 25 commands so the
    // fill level sweeps between empty and full
    enq_bias = 50;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (int n = 0; n < 125; n++) begin
        if (n % 25 == 0) begin
          sel = $urandom_range(2);
          enq_bias = (sel == 0) ? 80 : (sel == 1) ? 50 : 20;
        end
        // one stretch without gaps inside the idle phases
        if (ph != 0 && n == 60) idle_pct = 0;
        if (ph != 0 && n == 85) idle_pct = phase_idle[ph];
        c   = ($urandom_range(99) < enq_bias) ? CMD_ENQ : CMD_DEQ;
        sel = $urandom_range(9);
        v   = (sel == 0) ? 32'sh80000000 : (sel == 1) ? 32'sh7fffffff : $urandom;
        sel = $urandom_range(9);
        if (sel < 5) p = 8'($urandom_range(3));
        else if (sel < 8) p = 8'($urandom_range(255));
        else p = (sel == 8) ? 8'd0 : 8'd255;
        send_cmd(c, v, p);
      end
      drain_results();
    end

    // Settle: outstanding results are already in before the verdict
    repeat (8) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/spq_pkg.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/sorted_priority_queue.sv
dv/spq_checker.sv
dv/tb_sorted_priority_queue.sv
